// File: hdl/bdc_pkg.sv
package bdc_pkg;

  localparam int MAX_DIM       = 4096;
  localparam int CORDIC_STEPS  = 16;
  localparam int OUT_FRAC_BITS = 8;

  localparam int DIM_W  = 13;
  localparam int PIX_W  = 12;
  localparam int GAIN_W = 16;
  localparam int OUT_W  = 24;
  localparam int NORM_FRAC = 16;
  localparam int GAIN_FRAC = 12;

  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  localparam int CLAMP_W = ($clog2(MAX_DIM + 1) > DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W;
  localparam int CW      = $clog2(MAX_DIM / 2 + 1);
  localparam int OFF_W   = ((CW > PIX_W) ? CW : PIX_W) + 1;
  localparam int MAG_W   = OFF_W - 1;

  localparam int QW         = MAG_W + NORM_FRAC;
  localparam int DIV_PER    = 4;
  localparam int DIV_STAGES = (QW + DIV_PER - 1) / DIV_PER;
  localparam int DVD_W      = DIV_STAGES * DIV_PER;
  localparam int DRW        = CW + 1;

  localparam int SQ_W      = 2 * QW;
  localparam int SUM_W     = SQ_W + 1;
  localparam int SQ_PER    = 2;
  localparam int SQ_STAGES = (QW + 1 + SQ_PER - 1) / SQ_PER;
  localparam int ROOT_W    = SQ_STAGES * SQ_PER;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int SRW       = ROOT_W + 3;

  localparam int XY_W = ROOT_W + 4;
  localparam int TH_W = 20;
  localparam int ATAN_LEN = 24;
  localparam logic [16:0] ATAN_TAB [ATAN_LEN] = '{
    17'd51472, 17'd30385, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
    17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2,
    17'd1, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
  };

  localparam int KT_W   = GAIN_W + TH_W;
  localparam int PROD_W = KT_W + OFF_W;
  localparam int V_W    = PROD_W + 1;
  localparam int OUT_SH = NORM_FRAC + GAIN_FRAC - OUT_FRAC_BITS;

  localparam int ST_DIV0  = 1;
  localparam int ST_SQR   = ST_DIV0 + DIV_STAGES;
  localparam int ST_SUM   = ST_SQR + 1;
  localparam int ST_SQRT0 = ST_SUM + 1;
  localparam int ST_CRD0  = ST_SQRT0 + SQ_STAGES;
  localparam int ST_KT    = ST_CRD0 + CORDIC_STEPS;
  localparam int ST_PROD  = ST_KT + 1;
  localparam int ST_OUT   = ST_PROD + 1;
  localparam int NST      = ST_OUT + 1;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_GAIN   = 2'd2;

endpackage

// File: hdl/bdc_pix_if.sv
interface bdc_pix_if;
  import bdc_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pix_x;
  logic [PIX_W-1:0] pix_y;
  modport source (output valid, output pix_x, output pix_y, input ready);
  modport sink   (input valid, input pix_x, input pix_y, output ready);
endinterface

// File: hdl/bdc_src_if.sv
interface bdc_src_if;
  import bdc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] src_x;
  logic signed [OUT_W-1:0] src_y;
  logic                    clipped;
  modport source (output valid, output src_x, output src_y, output clipped, input ready);
  modport sink   (input valid, input src_x, input src_y, input clipped, output ready);
endinterface

// File: hdl/bdc_div_pipe.sv
module bdc_div_pipe (
  input  logic                          clk_i,
  input  logic [bdc_pkg::DIV_STAGES-1:0] en_i,
  input  logic [bdc_pkg::MAG_W-1:0]     mag_i,
  input  logic [bdc_pkg::CW-1:0]        dvs_i,
  output logic [bdc_pkg::QW-1:0]        quo_o
);
  import bdc_pkg::*;

  logic [DRW-1:0]   rem_in [DIV_STAGES];
  logic [DRW-1:0]   rem_d  [DIV_STAGES];
  logic [DRW-1:0]   rem_q  [DIV_STAGES];
  logic [DVD_W-1:0] dvd_in [DIV_STAGES];
  logic [DVD_W-1:0] dvd_d  [DIV_STAGES];
  logic [DVD_W-1:0] dvd_q  [DIV_STAGES];
  logic [DVD_W-1:0] quo_in [DIV_STAGES];
  logic [DVD_W-1:0] quo_d  [DIV_STAGES];
  logic [DVD_W-1:0] quo_q  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rem_in[s] = '0;
      assign dvd_in[s] = DVD_W'(mag_i) << NORM_FRAC;
      assign quo_in[s] = '0;
    end else begin : g_next
      assign rem_in[s] = rem_q[s-1];
      assign dvd_in[s] = dvd_q[s-1];
      assign quo_in[s] = quo_q[s-1];
    end

    always_comb begin
      logic [DRW-1:0]   r;
      logic [DVD_W-1:0] dv;
      logic [DVD_W-1:0] q;
      r  = rem_in[s];
      dv = dvd_in[s];
      q  = quo_in[s];
      for (int k = 0; k < DIV_PER; k++) begin
        r  = {r[DRW-2:0], dv[DVD_W-1]};
        dv = dv << 1;
        if (r >= DRW'(dvs_i)) begin
          r = r - DRW'(dvs_i);
          q = {q[DVD_W-2:0], 1'b1};
        end else begin
          q = {q[DVD_W-2:0], 1'b0};
        end
      end
      rem_d[s] = r;
      dvd_d[s] = dv;
      quo_d[s] = q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= rem_d[s];
        dvd_q[s] <= dvd_d[s];
        quo_q[s] <= quo_d[s];
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1][QW-1:0];

endmodule

// File: hdl/bdc_sqrt_pipe.sv
module bdc_sqrt_pipe (
  input  logic                         clk_i,
  input  logic [bdc_pkg::SQ_STAGES-1:0] en_i,
  input  logic [bdc_pkg::SUM_W-1:0]    rad_i,
  output logic [bdc_pkg::ROOT_W-1:0]   root_o
);
  import bdc_pkg::*;

  logic [SRW-1:0]    rem_in  [SQ_STAGES];
  logic [SRW-1:0]    rem_d   [SQ_STAGES];
  logic [SRW-1:0]    rem_q   [SQ_STAGES];
  logic [RAD_W-1:0]  rad_in  [SQ_STAGES];
  logic [RAD_W-1:0]  rad_d   [SQ_STAGES];
  logic [RAD_W-1:0]  rad_q   [SQ_STAGES];
  logic [ROOT_W-1:0] root_in [SQ_STAGES];
  logic [ROOT_W-1:0] root_d  [SQ_STAGES];
  logic [ROOT_W-1:0] root_q  [SQ_STAGES];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rem_in[s]  = '0;
      assign rad_in[s]  = RAD_W'(rad_i);
      assign root_in[s] = '0;
    end else begin : g_next
      assign rem_in[s]  = rem_q[s-1];
      assign rad_in[s]  = rad_q[s-1];
      assign root_in[s] = root_q[s-1];
    end

    always_comb begin
      logic [SRW-1:0]    r;
      logic [SRW-1:0]    trial;
      logic [RAD_W-1:0]  rd;
      logic [ROOT_W-1:0] rt;
      r  = rem_in[s];
      rd = rad_in[s];
      rt = root_in[s];
      for (int k = 0; k < SQ_PER; k++) begin
        r     = {r[SRW-3:0], rd[RAD_W-1:RAD_W-2]};
        rd    = rd << 2;
        trial = SRW'({rt, 2'b01});
        if (r >= trial) begin
          r  = r - trial;
          rt = {rt[ROOT_W-2:0], 1'b1};
        end else begin
          rt = {rt[ROOT_W-2:0], 1'b0};
        end
      end
      rem_d[s]  = r;
      rad_d[s]  = rd;
      root_d[s] = rt;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s]  <= rem_d[s];
        rad_q[s]  <= rad_d[s];
        root_q[s] <= root_d[s];
      end
    end
  end

  assign root_o = root_q[SQ_STAGES-1];

endmodule

// File: hdl/bdc_cordic_pipe.sv
module bdc_cordic_pipe (
  input  logic                            clk_i,
  input  logic [bdc_pkg::CORDIC_STEPS-1:0] en_i,
  input  logic [bdc_pkg::ROOT_W-1:0]      r_i,
  output logic signed [bdc_pkg::TH_W-1:0] theta_o
);
  import bdc_pkg::*;

  logic signed [XY_W-1:0] x_in [CORDIC_STEPS];
  logic signed [XY_W-1:0] x_d  [CORDIC_STEPS];
  logic signed [XY_W-1:0] x_q  [CORDIC_STEPS];
  logic signed [XY_W-1:0] y_in [CORDIC_STEPS];
  logic signed [XY_W-1:0] y_d  [CORDIC_STEPS];
  logic signed [XY_W-1:0] y_q  [CORDIC_STEPS];
  logic signed [TH_W-1:0] z_in [CORDIC_STEPS];
  logic signed [TH_W-1:0] z_d  [CORDIC_STEPS];
  logic signed [TH_W-1:0] z_q  [CORDIC_STEPS];

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign x_in[s] = XY_W'(1) <<< NORM_FRAC;
      assign y_in[s] = $signed(XY_W'(r_i));
      assign z_in[s] = '0;
    end else begin : g_next
      assign x_in[s] = x_q[s-1];
      assign y_in[s] = y_q[s-1];
      assign z_in[s] = z_q[s-1];
    end

    always_comb begin
      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      logic signed [TH_W-1:0] ang;
      dx  = y_in[s] >>> s;
      dy  = x_in[s] >>> s;
      ang = $signed(TH_W'(ATAN_TAB[s]));
      if (!y_in[s][XY_W-1]) begin
        x_d[s] = x_in[s] + dx;
        y_d[s] = y_in[s] - dy;
        z_d[s] = z_in[s] + ang;
      end else begin
        x_d[s] = x_in[s] - dx;
        y_d[s] = y_in[s] + dy;
        z_d[s] = z_in[s] - ang;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        x_q[s] <= x_d[s];
        y_q[s] <= y_d[s];
        z_q[s] <= z_d[s];
      end
    end
  end

  assign theta_o = z_q[CORDIC_STEPS-1];

endmodule

// File: hdl/barrel_distortion_coord_map_unit.sv
// channel   dir  beat payload              width
// pix_i     in   pix_x, pix_y           12 + 12 unsigned
// src_o     out  src_x, src_y, clipped  24 + 24 signed Q16.8, 1
// apb       in   paddr, pwdata/prdata   4 / 32, regs at 0x0 0x4 0x8
//
// One beat per cycle sustained while src_o.ready is high.
// The pipeline depth is set mostly by the normalizing divider, square root and CORDIC stages.
// Valid bits reset asynchronously on rst_ni low; data registers do not reset.
// A held output stalls only the stages that hold data behind it; bubbles fill.
module barrel_distortion_coord_map_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bdc_pix_if.sink                     pix_i,
  bdc_src_if.source                   src_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdc_pkg::ADDR_W-1:0]  paddr,
  input  logic [bdc_pkg::DATA_W-1:0]  pwdata,
  output logic [bdc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import bdc_pkg::*;

  logic [DIM_W-1:0]         width_q;
  logic [DIM_W-1:0]         height_q;
  logic signed [GAIN_W-1:0] gain_q;
  logic [1:0]               reg_idx;

  logic [CLAMP_W-1:0] w_ext, h_ext, w_eff, h_eff;
  logic [CW-1:0]      cx, cy;

  logic [NST-1:0] en;
  logic [NST-1:0] v_q;

  logic signed [OFF_W-1:0] offx_d, offy_d;
  logic signed [OFF_W-1:0] offx_q [ST_PROD];
  logic signed [OFF_W-1:0] offy_q [ST_PROD];
  logic [MAG_W-1:0]        magx_q, magy_q;

  logic [QW-1:0]           quo_x, quo_y, nx, ny;
  logic [SQ_W-1:0]         sqx_q, sqy_q;
  logic [SUM_W-1:0]        sum_q;
  logic [ROOT_W-1:0]       root;
  logic signed [TH_W-1:0]  theta;
  logic signed [KT_W-1:0]  kt_q;
  logic signed [PROD_W-1:0] prodx_q, prody_q;
  logic signed [V_W-1:0]   vx, vy;
  logic                    satx, saty;
  logic signed [OUT_W-1:0] srcx_q, srcy_q;
  logic                    clip_q;

  localparam logic signed [V_W-1:0] V_MAX = V_W'(OUT_MAX);
  localparam logic signed [V_W-1:0] V_MIN = V_W'(OUT_MIN);
  localparam logic signed [V_W-1:0] V_RND = V_W'(1) <<< (OUT_SH - 1);

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(640);
      height_q <= DIM_W'(480);
      gain_q   <= GAIN_W'(4096);
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        REG_GAIN:   gain_q   <= $signed(pwdata[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = DATA_W'(width_q);
      REG_HEIGHT: prdata = DATA_W'(height_q);
      REG_GAIN:   prdata = DATA_W'($unsigned(gain_q));
      default:    prdata = '0;
    endcase
  end

  assign w_ext = CLAMP_W'(width_q);
  assign h_ext = CLAMP_W'(height_q);
  assign w_eff = (w_ext > CLAMP_W'(MAX_DIM)) ? CLAMP_W'(MAX_DIM) : w_ext;
  assign h_eff = (h_ext > CLAMP_W'(MAX_DIM)) ? CLAMP_W'(MAX_DIM) : h_ext;
  assign cx    = CW'(w_eff >> 1);
  assign cy    = CW'(h_eff >> 1);

  // stall chain: a stage loads when empty or when the next one loads
  always_comb begin
    en[NST-1] = !v_q[NST-1] || src_o.ready;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign pix_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= pix_i.valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  assign offx_d = $signed(OFF_W'(pix_i.pix_x)) - $signed(OFF_W'(cx));
  assign offy_d = $signed(OFF_W'(pix_i.pix_y)) - $signed(OFF_W'(cy));

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      offx_q[0] <= offx_d;
      offy_q[0] <= offy_d;
      magx_q    <= MAG_W'(offx_d[OFF_W-1] ? -offx_d : offx_d);
      magy_q    <= MAG_W'(offy_d[OFF_W-1] ? -offy_d : offy_d);
    end
  end

  for (genvar s = 1; s < ST_PROD; s++) begin : g_off
    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        offx_q[s] <= offx_q[s-1];
        offy_q[s] <= offy_q[s-1];
      end
    end
  end

  bdc_div_pipe u_div_x (
    .clk_i (clk_i),
    .en_i  (en[ST_DIV0 +: DIV_STAGES]),
    .mag_i (magx_q),
    .dvs_i (cx),
    .quo_o (quo_x)
  );

  bdc_div_pipe u_div_y (
    .clk_i (clk_i),
    .en_i  (en[ST_DIV0 +: DIV_STAGES]),
    .mag_i (magy_q),
    .dvs_i (cy),
    .quo_o (quo_y)
  );

  assign nx = (cx == '0) ? '0 : quo_x;
  assign ny = (cy == '0) ? '0 : quo_y;

  always_ff @(posedge clk_i) begin
    if (en[ST_SQR]) begin
      sqx_q <= nx * nx;
      sqy_q <= ny * ny;
    end
    if (en[ST_SUM]) begin
      sum_q <= SUM_W'(sqx_q) + SUM_W'(sqy_q);
    end
  end

  bdc_sqrt_pipe u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en[ST_SQRT0 +: SQ_STAGES]),
    .rad_i  (sum_q),
    .root_o (root)
  );

  bdc_cordic_pipe u_cordic (
    .clk_i   (clk_i),
    .en_i    (en[ST_CRD0 +: CORDIC_STEPS]),
    .r_i     (root),
    .theta_o (theta)
  );

  always_ff @(posedge clk_i) begin
    if (en[ST_KT]) begin
      kt_q <= KT_W'(gain_q) * KT_W'(theta);
    end
    if (en[ST_PROD]) begin
      prodx_q <= PROD_W'(kt_q) * PROD_W'(offx_q[ST_PROD-1]);
      prody_q <= PROD_W'(kt_q) * PROD_W'(offy_q[ST_PROD-1]);
    end
  end

  always_comb begin
    vx   = ((V_W'(prodx_q) + V_RND) >>> OUT_SH) + $signed(V_W'(cx) << OUT_FRAC_BITS);
    vy   = ((V_W'(prody_q) + V_RND) >>> OUT_SH) + $signed(V_W'(cy) << OUT_FRAC_BITS);
    satx = (vx > V_MAX) || (vx < V_MIN);
    saty = (vy > V_MAX) || (vy < V_MIN);
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      srcx_q <= (vx > V_MAX) ? OUT_W'(V_MAX) : ((vx < V_MIN) ? OUT_W'(V_MIN) : OUT_W'(vx));
      srcy_q <= (vy > V_MAX) ? OUT_W'(V_MAX) : ((vy < V_MIN) ? OUT_W'(V_MIN) : OUT_W'(vy));
      clip_q <= satx || saty;
    end
  end

  assign src_o.valid   = v_q[NST-1];
  assign src_o.src_x   = srcx_q;
  assign src_o.src_y   = srcy_q;
  assign src_o.clipped = clip_q;

endmodule
